FILE: design/npcs_pkg.sv
// Shared types and constants for the nearest palette colour search block.
`timescale 1ns / 1ps

package npcs_pkg;

   // Field widths fixed by the item format
   localparam int CHAN_W  = 8;
   localparam int INDEX_W = 8;
   localparam int DIST_W  = 18;
   localparam int COLOUR_W = 3 * CHAN_W;

   // Largest palette the index field can address
   localparam int STORE_DEPTH_MAX = 256;
   localparam int PALETTE_ENTRIES_DEFAULT = 256;

   // Item command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Starting best distance: above any reachable distance (max 3*255*255)
   localparam logic [DIST_W-1:0] NO_DISTANCE_YET = {DIST_W{1'b1}};
   localparam logic [DIST_W-1:0] MAX_DISTANCE = DIST_W'(195075);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } colour_type;

   // Tag that travels down the distance pipeline with each palette entry
   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] index;
   } scan_tag_type;

endpackage

FILE: design/npcs_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module npcs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable, register the read word every cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/npcs_dist.sv
// Squared RGB distance stage: registered channel squares, summed on the way out.
`timescale 1ns / 1ps

module npcs_dist (
   input  logic                          clock,
   input  logic                          reset,
   input  npcs_pkg::scan_tag_type        in_tag,
   input  npcs_pkg::colour_type          pixel,
   input  npcs_pkg::colour_type          entry,
   output npcs_pkg::scan_tag_type        out_tag,
   output logic [npcs_pkg::DIST_W-1:0]   out_dist
);

   localparam int SQ_W = 2 * npcs_pkg::CHAN_W;

   function automatic logic [SQ_W-1:0] gap_squared(
      input logic [npcs_pkg::CHAN_W-1:0] a,
      input logic [npcs_pkg::CHAN_W-1:0] b
   );
      logic [npcs_pkg::CHAN_W-1:0] gap;
      gap = (a >= b) ? (a - b) : (b - a);
      return SQ_W'(gap) * SQ_W'(gap);
   endfunction

   npcs_pkg::scan_tag_type tag_ff, tag_in;
   logic [SQ_W-1:0] sq_r_ff, sq_g_ff, sq_b_ff;
   logic [SQ_W-1:0] sq_r_in, sq_g_in, sq_b_in;

   // Square each channel gap
   always_comb begin
      tag_in  = in_tag;
      sq_r_in = gap_squared(pixel.red,   entry.red);
      sq_g_in = gap_squared(pixel.green, entry.green);
      sq_b_in = gap_squared(pixel.blue,  entry.blue);
   end

   // Hold the tag valid under reset, squares need none
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff.valid <= tag_in.valid;
      end
      tag_ff.index <= tag_in.index;
      sq_r_ff      <= sq_r_in;
      sq_g_ff      <= sq_g_in;
      sq_b_ff      <= sq_b_in;
   end

   assign out_tag  = tag_ff;
   assign out_dist = npcs_pkg::DIST_W'(sq_r_ff) + npcs_pkg::DIST_W'(sq_g_ff)
                   + npcs_pkg::DIST_W'(sq_b_ff);

endmodule

FILE: design/nearest_palette_colour_search_top.sv
// Top level of the nearest palette colour search block.
// Write item: accepted with no result; the next item may follow at once.
// Query item: one palette read per cycle through the single RAM port, then the
// distance stage and the best-distance register; the next item is taken once the
// result is in the output register.
// Reset clears one valid flag per entry at once; an unwritten entry reads as black.
`timescale 1ns / 1ps

module nearest_palette_colour_search_top #(
   parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [npcs_pkg::INDEX_W-1:0]      req_entry_index,
   input  logic [npcs_pkg::CHAN_W-1:0]       req_red,
   input  logic [npcs_pkg::CHAN_W-1:0]       req_green,
   input  logic [npcs_pkg::CHAN_W-1:0]       req_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [npcs_pkg::INDEX_W-1:0]      rsp_best_index,
   output logic [npcs_pkg::DIST_W-1:0]       rsp_best_distance
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
   localparam logic [npcs_pkg::INDEX_W:0] ENTRY_LIMIT =
      (npcs_pkg::INDEX_W + 1)'(PALETTE_ENTRIES);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [PALETTE_ENTRIES-1:0] valid_ff, valid_in;
   npcs_pkg::colour_type pixel_ff, pixel_in;
   npcs_pkg::scan_tag_type rd_tag_ff, rd_tag_in;
   logic ent_valid_ff, ent_valid_in;
   logic [npcs_pkg::DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [npcs_pkg::INDEX_W-1:0] best_idx_ff, best_idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [npcs_pkg::INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [npcs_pkg::DIST_W-1:0] rsp_dist_ff, rsp_dist_in;

   logic req_accept, query_accept, ram_we, drain_done, rsp_load;
   logic [IDX_W-1:0] ram_addr;
   logic [npcs_pkg::COLOUR_W-1:0] ram_wdata, ram_rdata;
   npcs_pkg::colour_type entry_rd;
   npcs_pkg::scan_tag_type dist_tag;
   logic [npcs_pkg::DIST_W-1:0] dist_val;

   // Take items only between queries
   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign query_accept = req_accept && (req_cmd == npcs_pkg::CMD_QUERY);
   assign ram_we       = req_accept && (req_cmd == npcs_pkg::CMD_WRITE)
                       && ({1'b0, req_entry_index} < ENTRY_LIMIT);
   assign ram_addr     = (state_ff == ST_SCAN) ? cnt_ff : req_entry_index[IDX_W-1:0];
   assign ram_wdata    = {req_red, req_green, req_blue};

   npcs_ram #(
      .WIDTH (npcs_pkg::COLOUR_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_npcs_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Unwritten entries read as black
   assign entry_rd = ent_valid_ff ? npcs_pkg::colour_type'(ram_rdata)
                                  : npcs_pkg::colour_type'('0);

   npcs_dist u_npcs_dist (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (rd_tag_ff),
      .pixel    (pixel_ff),
      .entry    (entry_rd),
      .out_tag  (dist_tag),
      .out_dist (dist_val)
   );

   assign drain_done = (state_ff == ST_DRAIN) && !rd_tag_ff.valid && !dist_tag.valid;
   assign rsp_load   = drain_done && (!rsp_valid_ff || !rsp_stall);

   // Sequencer: scan the palette, drain the pipeline, hand over the result
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      pixel_in     = pixel_ff;
      rd_tag_in    = '{valid: 1'b0, index: npcs_pkg::INDEX_W'(cnt_ff)};
      ent_valid_in = valid_ff[cnt_ff];
      if (ram_we) begin
         valid_in[req_entry_index[IDX_W-1:0]] = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (query_accept) begin
               pixel_in = '{red: req_red, green: req_green, blue: req_blue};
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_tag_in.valid = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Keep the first strictly smaller distance
   always_comb begin
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (query_accept) begin
         best_dist_in = npcs_pkg::NO_DISTANCE_YET;
         best_idx_in  = '0;
      end else if (dist_tag.valid && (dist_val < best_dist_ff)) begin
         best_dist_in = dist_val;
         best_idx_in  = dist_tag.index;
      end
   end

   // Output register: load on finish, drop on handover
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_dist_in  = rsp_dist_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = best_idx_ff;
         rsp_dist_in  = best_dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         valid_ff        <= '0;
         rd_tag_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         valid_ff        <= valid_in;
         rd_tag_ff.valid <= rd_tag_in.valid;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rd_tag_ff.index <= rd_tag_in.index;
      ent_valid_ff    <= ent_valid_in;
      pixel_ff        <= pixel_in;
      best_dist_ff    <= best_dist_in;
      best_idx_ff     <= best_idx_in;
      rsp_idx_ff      <= rsp_idx_in;
      rsp_dist_ff     <= rsp_dist_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_index    = rsp_idx_ff;
   assign rsp_best_distance = rsp_dist_ff;

endmodule

FILE: design/npcs_checker.sv
// Port-level assertions for the nearest palette colour search block, with bind.
`timescale 1ns / 1ps

module npcs_checker #(
   parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_cmd,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [npcs_pkg::INDEX_W-1:0]  rsp_best_index,
   input logic [npcs_pkg::DIST_W-1:0]   rsp_best_distance
);

   localparam logic [npcs_pkg::INDEX_W:0] ENTRY_LIMIT =
      (npcs_pkg::INDEX_W + 1)'(PALETTE_ENTRIES);

   // A query occupies the block: the next item waits
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_cmd == npcs_pkg::CMD_QUERY) |=> req_stall)
      else $error("item accepted straight after a query");

   // A palette write never blocks the following item
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_cmd == npcs_pkg::CMD_WRITE) |=> !req_stall)
      else $error("stall raised after a palette write");

   // Result lies within the palette and the distance range
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (({1'b0, rsp_best_index} < ENTRY_LIMIT)
                     && (rsp_best_distance <= npcs_pkg::MAX_DISTANCE)))
      else $error("result index or distance out of range");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_best_index)
                                    && $stable(rsp_best_distance)))
      else $error("stalled result dropped or changed");

endmodule

bind nearest_palette_colour_search_top npcs_checker #(
   .PALETTE_ENTRIES (PALETTE_ENTRIES)
) u_npcs_checker (.*);

FILE: tb/tb_nearest_palette_colour_search_top.sv
// Self-checking testbench for the nearest palette colour search block.
`timescale 1ns / 1ps

module tb_nearest_palette_colour_search_top;

   localparam int CHAN_W   = npcs_pkg::CHAN_W;
   localparam int INDEX_W  = npcs_pkg::INDEX_W;
   localparam int DIST_W   = npcs_pkg::DIST_W;
   localparam int COLOUR_W = npcs_pkg::COLOUR_W;
   localparam logic CMD_WRITE = npcs_pkg::CMD_WRITE;
   localparam logic CMD_QUERY = npcs_pkg::CMD_QUERY;
   localparam logic [DIST_W-1:0] MAX_DISTANCE = npcs_pkg::MAX_DISTANCE;

   typedef npcs_pkg::colour_type colour_type;

   localparam int PAL_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEFAULT;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 1200;
   localparam int NUM_DIR     = 22;

   // Expected answer of one query
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [DIST_W-1:0]  distance;
   } nearest_type;

   // One stimulus row; typed rows carry their answer, the rest use the shadow search
   typedef struct packed {
      logic               cmd;
      logic [INDEX_W-1:0] index;
      colour_type         colour;
      logic               typed;
      logic [INDEX_W-1:0] exp_index;
      logic [DIST_W-1:0]  exp_dist;
   } stim_row_type;

   localparam stim_row_type DIR_ROWS [NUM_DIR] = '{
      // all black after reset
      '{CMD_QUERY, 8'd0,   '{8'd0,   8'd0,   8'd0},   1'b1, 8'd0,   18'd0},
      '{CMD_QUERY, 8'd255, '{8'd255, 8'd255, 8'd255}, 1'b1, 8'd0,   MAX_DISTANCE},
      // white in the top entry
      '{CMD_WRITE, 8'd255, '{8'd255, 8'd255, 8'd255}, 1'b0, 8'd0,   18'd0},
      '{CMD_QUERY, 8'd0,   '{8'd255, 8'd255, 8'd255}, 1'b1, 8'd255, 18'd0},
      '{CMD_QUERY, 8'd170, '{8'd0,   8'd0,   8'd0},   1'b1, 8'd0,   18'd0},
      // red in entry 0, black now first found at entry 1
      '{CMD_WRITE, 8'd0,   '{8'd255, 8'd0,   8'd0},   1'b0, 8'd0,   18'd0},
      '{CMD_QUERY, 8'd0,   '{8'd0,   8'd0,   8'd0},   1'b1, 8'd1,   18'd0},
      '{CMD_QUERY, 8'd0,   '{8'd255, 8'd0,   8'd0},   1'b1, 8'd0,   18'd0},
      // equal colours in two entries: the lower index wins
      '{CMD_WRITE, 8'd7,   '{8'd12,  8'd34,  8'd56},  1'b0, 8'd0,   18'd0},
      '{CMD_WRITE, 8'd9,   '{8'd12,  8'd34,  8'd56},  1'b0, 8'd0,   18'd0},
      '{CMD_QUERY, 8'd85,  '{8'd12,  8'd34,  8'd56},  1'b1, 8'd7,   18'd0},
      '{CMD_QUERY, 8'd0,   '{8'd13,  8'd34,  8'd56},  1'b0, 8'd0,   18'd0},
      '{CMD_WRITE, 8'd128, '{8'd0,   8'd255, 8'd0},   1'b0, 8'd0,   18'd0},
      '{CMD_QUERY, 8'd0,   '{8'd0,   8'd255, 8'd0},   1'b1, 8'd128, 18'd0},
      '{CMD_WRITE, 8'd64,  '{8'd0,   8'd0,   8'd255}, 1'b0, 8'd0,   18'd0},
      '{CMD_QUERY, 8'd0,   '{8'd0,   8'd0,   8'd255}, 1'b1, 8'd64,  18'd0},
      // near-black in entry 1 pushes the first black to entry 2
      '{CMD_WRITE, 8'd1,   '{8'd1,   8'd1,   8'd1},   1'b0, 8'd0,   18'd0},
      '{CMD_QUERY, 8'd0,   '{8'd0,   8'd0,   8'd0},   1'b1, 8'd2,   18'd0},
      '{CMD_QUERY, 8'd0,   '{8'd128, 8'd128, 8'd128}, 1'b0, 8'd0,   18'd0},
      '{CMD_QUERY, 8'd0,   '{8'd255, 8'd255, 8'd0},   1'b0, 8'd0,   18'd0},
      '{CMD_WRITE, 8'd200, '{8'd170, 8'd85,  8'd170}, 1'b0, 8'd0,   18'd0},
      '{CMD_QUERY, 8'd0,   '{8'd171, 8'd84,  8'd170}, 1'b0, 8'd0,   18'd0}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_cmd = CMD_WRITE;
   logic [INDEX_W-1:0]  req_entry_index = '0;
   logic [CHAN_W-1:0]   req_red = '0;
   logic [CHAN_W-1:0]   req_green = '0;
   logic [CHAN_W-1:0]   req_blue = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [INDEX_W-1:0]  rsp_best_index;
   logic [DIST_W-1:0]   rsp_best_distance;

   colour_type          pal_shadow [PAL_ENTRIES];
   nearest_type         nearest_due [$];
   nearest_type         want;

   int snd_idle_pct = 8;
   int rcv_idle_pct = 77;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int queries_sent = 0;
   int results_seen = 0;
   int errors = 0;

   nearest_palette_colour_search_top #(
      .PALETTE_ENTRIES (PAL_ENTRIES)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_best_index    (rsp_best_index),
      .rsp_best_distance (rsp_best_distance)
   );

   // Clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hold reset at the start, then release it
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Search the shadow palette: first entry with the strictly smallest distance
   function automatic nearest_type nearest_in_shadow(input colour_type px);
      int dr, dg, db, d, best;
      nearest_type res;
      best = 32'h7fffffff;
      res = '0;
      for (int p = 0; p < PAL_ENTRIES; p++) begin
         dr = int'(px.red)   - int'(pal_shadow[p].red);
         dg = int'(px.green) - int'(pal_shadow[p].green);
         db = int'(px.blue)  - int'(pal_shadow[p].blue);
         d = dr * dr + dg * dg + db * db;
         if (d < best) begin
            best = d;
            res.index = INDEX_W'(p);
         end
      end
      res.distance = DIST_W'(best);
      return res;
   endfunction

   // Offer one item after random idle cycles; update the shadow once it is taken
   task automatic offer_item(input stim_row_type row);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= row.cmd;
      req_entry_index <= row.index;
      req_red         <= row.colour.red;
      req_green       <= row.colour.green;
      req_blue        <= row.colour.blue;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      items_sent++;
      if (row.cmd == CMD_WRITE) begin
         if (int'(row.index) < PAL_ENTRIES) pal_shadow[row.index] = row.colour;
      end else begin
         queries_sent++;
         if (row.typed) nearest_due.push_back('{row.exp_index, row.exp_dist});
         else nearest_due.push_back(nearest_in_shadow(row.colour));
      end
   endtask

   // Drop valid and wait for every outstanding query to be answered
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (nearest_due.size() != 0);
   endtask

   // Random items: mostly writes with ties and extremes; queries at, near or away from stored colours
   task automatic run_random(input int count);
      stim_row_type row;
      colour_type base;
      int pick;
      for (int i = 0; i < count; i++) begin
         row = '0;
         pick = $urandom_range(99);
         if ($urandom_range(99) < 55) begin
            row.cmd = CMD_WRITE;
            row.index = ($urandom_range(4) == 0) ? INDEX_W'($urandom_range(15))
                                                 : INDEX_W'($urandom_range(255));
            if (pick < 20) begin
               row.colour = pal_shadow[$urandom_range(PAL_ENTRIES - 1)];
            end else if (pick < 30) begin
               row.colour.red   = $urandom_range(1) ? 8'hff : 8'h00;
               row.colour.green = $urandom_range(1) ? 8'hff : 8'h00;
               row.colour.blue  = $urandom_range(1) ? 8'hff : 8'h00;
            end else begin
               row.colour = COLOUR_W'($urandom());
            end
         end else begin
            row.cmd = CMD_QUERY;
            row.index = INDEX_W'($urandom_range(255));
            base = pal_shadow[$urandom_range(PAL_ENTRIES - 1)];
            if (pick < 30) begin
               row.colour = base;
            end else if (pick < 50) begin
               row.colour.red   = base.red   ^ CHAN_W'($urandom_range(3));
               row.colour.green = base.green ^ CHAN_W'($urandom_range(3));
               row.colour.blue  = base.blue  ^ CHAN_W'($urandom_range(3));
            end else begin
               row.colour = COLOUR_W'($urandom());
            end
         end
         offer_item(row);
      end
   endtask

   // Stimulus: directed table, then three random phases
   initial begin : stimulus
      for (int p = 0; p < PAL_ENTRIES; p++) pal_shadow[p] = '0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);

      for (int i = 0; i < NUM_DIR; i++) offer_item(DIR_ROWS[i]);
      drain_results();
      run_random(170);
      drain_results();

      snd_idle_pct = 77;
      rcv_idle_pct = 8;
      run_random(170);
      drain_results();

      // No idling; the receiver holds off for a long stretch at the start
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      hold_requests++;
      run_random(160);
      drain_results();

      repeat (PAL_ENTRIES + 16) @(posedge clock);
      $display("Sent %0d items (%0d queries), checked %0d results, %0d mismatches",
               items_sent, queries_sent, results_seen, errors);
      $display("Covered reset black palette, ties, extremes, both idling mixes and a long stall");
      if (errors == 0) begin
         $display("nearest_palette_colour_search_top test passed");
      end else begin
         $display("nearest_palette_colour_search_top test failed");
      end
      $finish;
   end

   // Result side: random stall, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_served + 1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // Compare each accepted result with the oldest expected answer
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (nearest_due.size() == 0) begin
            $display("%0t: unexpected result: index %0d distance %0d",
                     $time, rsp_best_index, rsp_best_distance);
            errors++;
         end else begin
            want = nearest_due.pop_front();
            results_seen++;
            if (rsp_best_index !== want.index) begin
               $display("%0t: best_index mismatch: expected %0d actual %0d",
                        $time, want.index, rsp_best_index);
               errors++;
            end
            if (rsp_best_distance !== want.distance) begin
               $display("%0t: best_distance mismatch: expected %0d actual %0d",
                        $time, want.distance, rsp_best_distance);
               errors++;
            end
         end
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, nearest_due.size());
         $display("nearest_palette_colour_search_top test failed");
         $finish;
      end
   end

endmodule

FILE: filelist.f
design/npcs_pkg.sv
design/npcs_ram.sv
design/npcs_dist.sv
design/nearest_palette_colour_search_top.sv
design/npcs_checker.sv
tb/tb_nearest_palette_colour_search_top.sv
